FILE: rtl/nses_pkg.sv
// shared constants, types and codes for the nearest sorted entry search
`timescale 1ns / 1ps

package nses_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_BITS  = 48;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int N_BITS      = IDX_BITS + 1;
   localparam int LCNT_BITS   = 11;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TEST,
      S_CMP,
      S_NB_LO,
      S_NB_HI,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_LOWER,
      RD_UPPER
   } rd_sel_type;

   typedef enum logic [1:0] {
      PICK_NONE,
      PICK_EDGE,
      PICK_NEAR,
      PICK_EMPTY
   } pick_op_type;

   typedef struct packed {
      logic        write;
      logic        load;
      logic        step;
      logic        cap_lower;
      rd_sel_type  rd_sel;
      pick_op_type pick_op;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic search_open;
      logic at_edge;
   } status_type;

endpackage

FILE: rtl/nearest_sorted_entry_search.sv
// top level of the nearest sorted entry search
// a write word is taken while idle and gives no result, and busy stays low; a query
// runs a binary search of at most 11 steps for 1024 entries, each a test and a compare
// state, then reads both neighbors and registers the nearer; no neighbor is read at a
// table end, nothing on an empty table, and the next word is taken after the result
// synchronous reset returns the controller to idle and line_count to zero
`timescale 1ns / 1ps

module nearest_sorted_entry_search
   import nses_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [VALUE_BITS-1:0] req_position_value,
   input  logic                  csr_wr_en,
   input  logic [LCNT_BITS-1:0]  csr_wr_data,
   output logic                  rsp_valid,
   output logic [IDX_BITS-1:0]   rsp_nearest_index,
   output logic                  rsp_table_empty
);

   cmd_type    cmd;
   status_type status;

   nses_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   nses_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_entry_index    (req_entry_index),
      .req_position_value (req_position_value),
      .rsp_nearest_index  (rsp_nearest_index),
      .rsp_table_empty    (rsp_table_empty)
   );

endmodule

FILE: rtl/nses_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module nses_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/nses_ctrl.sv
// controller state machine for the search sequence
`timescale 1ns / 1ps

module nses_ctrl
   import nses_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_func,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && (req_func == FUNC_QUERY)) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            priority if (status.n_zero) begin
               state_in = S_RESP;
            end else if (status.search_open) begin
               state_in = S_CMP;
            end else if (status.at_edge) begin
               state_in = S_RESP;
            end else begin
               state_in = S_NB_LO;
            end
         end
         S_CMP:   state_in = S_TEST;
         S_NB_LO: state_in = S_NB_HI;
         S_NB_HI: state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{write: 1'b0, load: 1'b0, step: 1'b0, cap_lower: 1'b0,
              rd_sel: RD_MID, pick_op: PICK_NONE};
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.write = (req_func == FUNC_WRITE);
               cmd.load  = (req_func == FUNC_QUERY);
            end
         end
         S_TEST: begin
            priority if (status.n_zero) begin
               cmd.pick_op = PICK_EMPTY;
            end else if (status.search_open) begin
               cmd.rd_sel = RD_MID;
            end else if (status.at_edge) begin
               cmd.pick_op = PICK_EDGE;
            end else begin
               cmd.rd_sel = RD_LOWER;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
         end
         S_NB_LO: begin
            cmd.cap_lower = 1'b1;
            cmd.rd_sel    = RD_UPPER;
         end
         S_NB_HI: begin
            cmd.pick_op = PICK_NEAR;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/nses_dp.sv
// datapath: line table, count register, search bounds and neighbor compare
`timescale 1ns / 1ps

module nses_dp
   import nses_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_wr_en,
   input  logic [LCNT_BITS-1:0]  csr_wr_data,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [VALUE_BITS-1:0] req_position_value,
   output logic [IDX_BITS-1:0]   rsp_nearest_index,
   output logic                  rsp_table_empty
);

   logic [LCNT_BITS-1:0]  line_count_ff;
   logic [N_BITS-1:0]     n_clamp;
   logic [N_BITS-1:0]     n_ff;
   logic [N_BITS-1:0]     lo_ff;
   logic [N_BITS-1:0]     hi_ff;
   logic [N_BITS-1:0]     mid;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] dist_lower_ff;
   logic [VALUE_BITS-1:0] dist_now;
   logic [IDX_BITS-1:0]   pick_ff;
   logic [IDX_BITS-1:0]   pick_in;
   logic                  empty_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   logic                  wr_en;
   logic                  entry_below;
   logic [VALUE_BITS:0]   diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
      end else if (csr_wr_en) begin
         line_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (32'(line_count_ff) > 32'(TABLE_DEPTH)) begin
         n_clamp = N_BITS'(TABLE_DEPTH);
      end else begin
         n_clamp = N_BITS'(line_count_ff);
      end
   end

   assign wr_en = cmd.write && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_MID:   rd_addr = IDX_BITS'(mid);
         RD_LOWER: rd_addr = IDX_BITS'(lo_ff - N_BITS'(1));
         RD_UPPER: rd_addr = IDX_BITS'(lo_ff);
         default:  rd_addr = IDX_BITS'(mid);
      endcase
   end

   nses_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_line_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data (req_position_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_below = $signed(rd_data) < $signed(val_ff);

   // absolute distance between query and the word just read
   assign diff = {val_ff[VALUE_BITS-1], val_ff} - {rd_data[VALUE_BITS-1], rd_data};
   assign dist_now = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : diff[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_position_value;
         n_ff   <= n_clamp;
         lo_ff  <= '0;
         hi_ff  <= n_clamp;
      end else if (cmd.step) begin
         if (entry_below) begin
            lo_ff <= mid + N_BITS'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.cap_lower) begin
         dist_lower_ff <= dist_now;
      end
   end

   always_comb begin
      unique case (cmd.pick_op)
         PICK_EDGE: begin
            if (lo_ff == '0) begin
               pick_in = '0;
            end else begin
               pick_in = IDX_BITS'(n_ff - N_BITS'(1));
            end
         end
         PICK_NEAR: begin
            if (dist_lower_ff < dist_now) begin
               pick_in = IDX_BITS'(lo_ff - N_BITS'(1));
            end else begin
               pick_in = IDX_BITS'(lo_ff);
            end
         end
         PICK_EMPTY: pick_in = '0;
         default:    pick_in = pick_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.pick_op != PICK_NONE) begin
         pick_ff  <= pick_in;
         empty_ff <= (cmd.pick_op == PICK_EMPTY);
      end
   end

   assign status.n_zero      = (n_ff == '0);
   assign status.search_open = (lo_ff < hi_ff);
   assign status.at_edge     = (lo_ff == '0) || (lo_ff == n_ff);

   assign rsp_nearest_index = pick_ff;
   assign rsp_table_empty   = empty_ff;

endmodule

FILE: test/nearest_entry_checker.sv
// checker that predicts nearest-entry answers and compares them with the result words
`timescale 1ns / 1ps

module nearest_entry_checker
   import nses_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_func,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [VALUE_BITS-1:0] req_position_value,
   input  logic                  csr_wr_en,
   input  logic [LCNT_BITS-1:0]  csr_wr_data,
   input  logic                  rsp_valid,
   input  logic [IDX_BITS-1:0]   rsp_nearest_index,
   input  logic                  rsp_table_empty,
   output int                    mismatches,
   output int                    answers_waiting
);

   typedef struct packed {
      logic [IDX_BITS-1:0] index;
      logic                empty;
   } answer_type;

   logic signed [VALUE_BITS-1:0] line_copy [TABLE_DEPTH];
   logic [LCNT_BITS-1:0]         count_copy;
   answer_type                   answers_due [$];

   function automatic longint gap_between(input logic signed [VALUE_BITS-1:0] a,
                                          input logic signed [VALUE_BITS-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic answer_type nearest_entry_of(input logic signed [VALUE_BITS-1:0] pos);
      int         n;
      int         lo;
      int         hi;
      int         mid;
      int         pick;
      answer_type a;
      n = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
      a.empty = (n == 0);
      a.index = '0;
      if (n != 0) begin
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (line_copy[mid] < pos) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         if (lo == 0) begin
            pick = 0;
         end else if (lo == n) begin
            pick = n - 1;
         end else begin
            // ties go to the upper neighbor
            pick = lo;
            if (gap_between(pos, line_copy[lo - 1]) < gap_between(pos, line_copy[lo])) begin
               pick = lo - 1;
            end
         end
         a.index = pick[IDX_BITS-1:0];
      end
      return a;
   endfunction

   task automatic flag_mismatch(input string why);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns: %s", $time, why);
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         count_copy = '0;
         answers_due.delete();
         mismatches = 0;
      end else begin
         if (start && !busy) begin
            if (req_func == FUNC_WRITE) begin
               line_copy[req_entry_index] = req_position_value;
            end else begin
               answers_due.push_back(nearest_entry_of(req_position_value));
            end
         end
         if (csr_wr_en) begin
            count_copy = csr_wr_data;
         end
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               flag_mismatch($sformatf("result word with no query waiting: index %0d empty %0b",
                                       rsp_nearest_index, rsp_table_empty));
            end else begin
               want = answers_due.pop_front();
               if (rsp_nearest_index !== want.index || rsp_table_empty !== want.empty) begin
                  flag_mismatch($sformatf({"result mismatch: expected index %0d empty %0b,",
                                           " got index %0d empty %0b"},
                                          want.index, want.empty,
                                          rsp_nearest_index, rsp_table_empty));
               end
            end
         end
      end
      answers_waiting = answers_due.size();
   end

endmodule

FILE: test/nearest_sorted_entry_search_test.sv
// testbench top: stimulus, count settings and verdict for the nearest sorted entry search
`timescale 1ns / 1ps

module nearest_sorted_entry_search_test;
   import nses_pkg::*;

   localparam int     HALF_PERIOD   = 10;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     RANDOM_WORDS  = 300;
   localparam int     SETTLE_CYCLES = 32;
   localparam longint MIN_POS       = -(longint'(1) << (VALUE_BITS - 1));
   localparam longint MAX_POS       = (longint'(1) << (VALUE_BITS - 1)) - 1;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  start              = 1'b0;
   logic                  busy;
   logic                  req_func           = FUNC_WRITE;
   logic [IDX_BITS-1:0]   req_entry_index    = '0;
   logic [VALUE_BITS-1:0] req_position_value = '0;
   logic                  csr_wr_en          = 1'b0;
   logic [LCNT_BITS-1:0]  csr_wr_data        = '0;
   logic                  rsp_valid;
   logic [IDX_BITS-1:0]   rsp_nearest_index;
   logic                  rsp_table_empty;

   int     mismatches;
   int     answers_waiting;
   int     cycle_count   = 0;
   int     words_sent    = 0;
   int     queries_sent  = 0;
   int     settings_made = 0;
   bit     quiet_phase   = 1'b0;
   longint line_shadow [TABLE_DEPTH];
   longint corner_probes [7] = '{MIN_POS, MIN_POS + 1, 0, -60, 99, MAX_POS - 1, MAX_POS};
   int     search_spine [20] = '{0, 1, 2, 4, 8, 16, 32, 64, 128, 256, 512, 768, 896, 960,
                                 992, 1008, 1016, 1020, 1022, 1023};

   nearest_sorted_entry_search u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_position_value (req_position_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_nearest_index  (rsp_nearest_index),
      .rsp_table_empty    (rsp_table_empty)
   );

   nearest_entry_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_position_value (req_position_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_nearest_index  (rsp_nearest_index),
      .rsp_table_empty    (rsp_table_empty),
      .mismatches         (mismatches),
      .answers_waiting    (answers_waiting)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers still due", cycle_count,
                  answers_waiting);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic longint any_position();
      logic [63:0]                  raw;
      logic signed [VALUE_BITS-1:0] pos;
      raw = {$urandom, $urandom};
      pos = raw[VALUE_BITS-1:0];
      return longint'(pos);
   endfunction

   // query near an entry, between two neighbors, or anywhere
   function automatic longint probe_position(input int n);
      int j;
      if (n == 0) begin
         return any_position();
      end
      j = $urandom_range(n - 1);
      case ($urandom_range(4))
         0: begin
            return any_position();
         end
         1, 2: begin
            return line_shadow[j] + longint'($urandom_range(4)) - 2;
         end
         default: begin
            if (j == 0) begin
               return line_shadow[0] - longint'($urandom_range(3));
            end
            return line_shadow[j - 1] + ((line_shadow[j] - line_shadow[j - 1]) >>> 1)
                   + longint'($urandom_range(2)) - 1;
         end
      endcase
   endfunction

   // query at or below the first entry or above the last one
   function automatic longint outer_position();
      case ($urandom_range(3))
         0:       return MIN_POS;
         1:       return line_shadow[0] - longint'($urandom_range(3));
         2:       return line_shadow[TABLE_DEPTH - 1] + 1 + longint'($urandom_range(3));
         default: return MAX_POS;
      endcase
   endfunction

   task automatic send_word(input logic func, input int index, input longint value);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(9);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_func           <= func;
      req_entry_index    <= index[IDX_BITS-1:0];
      req_position_value <= value[VALUE_BITS-1:0];
      do @(posedge clock); while (busy);
      words_sent++;
      if (func == FUNC_WRITE) begin
         line_shadow[index] = value;
      end else begin
         queries_sent++;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (answers_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_count(input int count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count[LCNT_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_made++;
   endtask

   // ascending entries 0..n-1, ties allowed
   task automatic fill_sorted(input int n);
      longint level;
      longint step_mask;
      case ($urandom_range(3))
         0:       step_mask = 64'h1;
         1:       step_mask = 64'hFF;
         2:       step_mask = 64'hFF_FFFF;
         default: step_mask = 64'hF_FFFF_FFFF;
      endcase
      level = any_position() >>> 2;
      for (int i = 0; i < n; i++) begin
         send_word(FUNC_WRITE, i, level);
         level += longint'({$urandom, $urandom}) & step_mask;
      end
   endtask

   // ascending entries only where a full-depth search below or above every entry reads
   task automatic fill_spine();
      longint level;
      level = any_position() >>> 4;
      foreach (search_spine[i]) begin
         send_word(FUNC_WRITE, search_spine[i], level);
         level += longint'($urandom_range(65535));
      end
   endtask

   initial begin
      int n;
      int first_random;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(FUNC_QUERY, 0, MIN_POS);
      send_word(FUNC_QUERY, TABLE_DEPTH - 1, MAX_POS);
      send_word(FUNC_WRITE, 0, MIN_POS);
      send_word(FUNC_WRITE, 1, -100);
      send_word(FUNC_WRITE, 2, 100);
      send_word(FUNC_WRITE, 3, MAX_POS);
      set_line_count(1);
      send_word(FUNC_QUERY, 0, 0);
      send_word(FUNC_QUERY, 0, MIN_POS);
      set_line_count(4);
      foreach (corner_probes[i]) begin
         send_word(FUNC_QUERY, i, corner_probes[i]);
      end
      set_line_count(3);
      send_word(FUNC_QUERY, 0, MAX_POS);
      send_word(FUNC_WRITE, TABLE_DEPTH - 1, MAX_POS);
      send_word(FUNC_WRITE, TABLE_DEPTH / 2, MIN_POS);
      send_word(FUNC_WRITE, 1, 500);
      send_word(FUNC_QUERY, 0, 200);
      set_line_count(0);
      send_word(FUNC_QUERY, 0, -1);

      first_random = words_sent;
      while (words_sent - first_random < RANDOM_WORDS) begin
         quiet_phase = ($urandom_range(4) == 0);
         case ($urandom_range(9))
            0:       n = 0;
            1:       n = $urandom_range(64, 17);
            default: n = $urandom_range(16, 1);
         endcase
         fill_sorted(n);
         if (n > 1 && $urandom_range(9) == 0) begin
            send_word(FUNC_WRITE, $urandom_range(n - 1), any_position());
         end
         set_line_count(n);
         repeat ($urandom_range(14, 6)) begin
            if ($urandom_range(4) == 0) begin
               send_word(FUNC_WRITE, $urandom_range(TABLE_DEPTH - 1), any_position());
            end else begin
               send_word(FUNC_QUERY, $urandom_range(TABLE_DEPTH - 1), probe_position(n));
            end
         end
      end

      // outer search paths of a full table, then a count past the table depth
      quiet_phase = 1'b0;
      fill_spine();
      set_line_count(TABLE_DEPTH);
      repeat (16) send_word(FUNC_QUERY, $urandom_range(TABLE_DEPTH - 1), outer_position());
      set_line_count((1 << LCNT_BITS) - 1);
      repeat (16) send_word(FUNC_QUERY, $urandom_range(TABLE_DEPTH - 1), outer_position());
      set_line_count(0);
      send_word(FUNC_QUERY, 0, any_position());

      drain();
      $display("%0d words sent, %0d of them queries, over %0d line count settings",
               words_sent, queries_sent, settings_made);
      $display("counts covered 0, 1, small, up to 64, full depth and the 11-bit maximum");
      if (mismatches == 0 && answers_waiting == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
